FILE: design/tomq_pkg.sv
// Package for the time-ordered message queue: action and status codes,
// the default queue depth and the control struct broadcast to the cell row.
// No dependencies.
package tomq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam int TIME_W   = 48;
    localparam int TAG_W    = 32;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 3;

    localparam logic [ACTION_W-1:0] ACT_ENQ  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DEQ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUIT = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_QUIT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REJECT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

    typedef struct packed {
        logic ins_en;
        logic deq_en;
    } cell_ctrl_t;

endpackage

FILE: design/time_ordered_message_queue.sv
// Top level of the time-ordered message queue: control, flags, output register
// and a row of tomq_cell instances. Depends on tomq_pkg and tomq_cell.
// The result of an accepted item is in the output register in the cycle after it is accepted.
// It accepts one item per cycle while in_ready is high, that is while the output register is empty or taken.
// Reset clears the entry count, the quit flags and the output valid; stored entries stay undefined.
module time_ordered_message_queue #(
    parameter int QUEUE_DEPTH = tomq_pkg::DEFAULT_QUEUE_DEPTH,
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tomq_pkg::ACTION_W-1:0] action,
    input  logic [tomq_pkg::TIME_W-1:0]   msg_time,
    input  logic [tomq_pkg::TAG_W-1:0]    msg_tag,
    input  logic                          safe_exit,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tomq_pkg::STATUS_W-1:0] status,
    output logic [tomq_pkg::TIME_W-1:0]   out_time,
    output logic [tomq_pkg::TAG_W-1:0]    out_tag,
    output logic [CW-1:0]                 occupancy
);
    import tomq_pkg::*;

    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    logic                in_acc;
    cell_ctrl_t          ctrl;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                quit_reg;
    logic                quit_next;
    logic                safe_reg;
    logic                safe_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [TIME_W-1:0]   out_time_reg;
    logic [TIME_W-1:0]   out_time_next;
    logic [TAG_W-1:0]    out_tag_reg;
    logic [TAG_W-1:0]    out_tag_next;
    logic [CW-1:0]       occ_reg;

    logic [QUEUE_DEPTH-1:0] cell_gt;
    logic [TIME_W-1:0]      cell_time [QUEUE_DEPTH];
    logic [TAG_W-1:0]       cell_tag  [QUEUE_DEPTH];

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_time  = out_time_reg;
    assign out_tag   = out_tag_reg;
    assign occupancy = occ_reg;

    always_comb
    begin
        ctrl          = '0;
        count_next    = count_reg;
        quit_next     = quit_reg;
        safe_next     = safe_reg;
        status_next   = ST_OK;
        out_time_next = '0;
        out_tag_next  = '0;
        unique case (action)
            ACT_ENQ:
            begin
                priority if (quit_reg)
                begin
                    status_next = ST_REJECT;
                end
                else if (count_reg == DEPTH_C)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl.ins_en = in_acc;
                    count_next  = count_reg + CW'(1);
                end
            end
            ACT_DEQ:
            begin
                priority if (quit_reg && !safe_reg)
                begin
                    status_next = ST_QUIT;
                end
                else if (count_reg == '0)
                begin
                    status_next = quit_reg ? ST_QUIT : ST_EMPTY;
                end
                else
                begin
                    ctrl.deq_en   = in_acc;
                    count_next    = count_reg - CW'(1);
                    out_time_next = cell_time[0];
                    out_tag_next  = cell_tag[0];
                end
            end
            ACT_QUIT:
            begin
                quit_next = 1'b1;
                safe_next = safe_exit;
            end
            ACT_NOP:
            begin
                status_next = ST_OK;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        if (in_acc)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            quit_reg      <= 1'b0;
            safe_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_acc)
            begin
                count_reg <= count_next;
                quit_reg  <= quit_next;
                safe_reg  <= safe_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            status_reg   <= status_next;
            out_time_reg <= out_time_next;
            out_tag_reg  <= out_tag_next;
            occ_reg      <= count_next;
        end
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic              left_gt;
        logic [TIME_W-1:0] left_time;
        logic [TAG_W-1:0]  left_tag;
        logic [TIME_W-1:0] right_time;
        logic [TAG_W-1:0]  right_tag;

        if (i == 0)
        begin : g_head
            assign left_gt   = 1'b0;
            assign left_time = msg_time;
            assign left_tag  = msg_tag;
        end
        else
        begin : g_mid
            assign left_gt   = cell_gt[i-1];
            assign left_time = cell_time[i-1];
            assign left_tag  = cell_tag[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_time = cell_time[i];
            assign right_tag  = cell_tag[i];
        end
        else
        begin : g_inner
            assign right_time = cell_time[i+1];
            assign right_tag  = cell_tag[i+1];
        end

        tomq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (count_reg > CW'(i)),
            .is_tail    (count_reg == CW'(i)),
            .key_time   (msg_time),
            .key_tag    (msg_tag),
            .left_gt    (left_gt),
            .left_time  (left_time),
            .left_tag   (left_tag),
            .right_time (right_time),
            .right_tag  (right_tag),
            .gt         (cell_gt[i]),
            .cur_time   (cell_time[i]),
            .cur_tag    (cell_tag[i])
        );
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count exceeds queue depth");

    a_quit_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && action == ACT_QUIT) |=> quit_reg)
        else $error("quit flag not set after quit item");

    a_enq_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && action == ACT_ENQ && !quit_reg && count_reg != DEPTH_C)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("accepted enqueue did not grow the queue");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (occupancy == DEPTH_C))
        else $error("full status with queue not full");

endmodule

FILE: design/tomq_cell.sv
// One storage cell of the sorted queue row. It holds one entry and takes
// its left or right neighbor's entry, or the new item, on insert and dequeue.
// Depends on tomq_pkg.
module tomq_cell (
    input  logic                       clk,
    input  tomq_pkg::cell_ctrl_t       ctrl,
    input  logic                       occupied,
    input  logic                       is_tail,
    input  logic [tomq_pkg::TIME_W-1:0] key_time,
    input  logic [tomq_pkg::TAG_W-1:0]  key_tag,
    input  logic                       left_gt,
    input  logic [tomq_pkg::TIME_W-1:0] left_time,
    input  logic [tomq_pkg::TAG_W-1:0]  left_tag,
    input  logic [tomq_pkg::TIME_W-1:0] right_time,
    input  logic [tomq_pkg::TAG_W-1:0]  right_tag,
    output logic                       gt,
    output logic [tomq_pkg::TIME_W-1:0] cur_time,
    output logic [tomq_pkg::TAG_W-1:0]  cur_tag
);
    import tomq_pkg::*;

    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] time_next;
    logic [TAG_W-1:0]  tag_reg;
    logic [TAG_W-1:0]  tag_next;

    // The stored entry is later than the new item, so the new item goes in front of it.
    assign gt       = occupied && (time_reg > key_time);
    assign cur_time = time_reg;
    assign cur_tag  = tag_reg;

    always_comb
    begin
        time_next = time_reg;
        tag_next  = tag_reg;
        priority if (ctrl.deq_en)
        begin
            time_next = right_time;
            tag_next  = right_tag;
        end
        else if (ctrl.ins_en && left_gt)
        begin
            time_next = left_time;
            tag_next  = left_tag;
        end
        else if (ctrl.ins_en && (gt || is_tail))
        begin
            time_next = key_time;
            tag_next  = key_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        tag_reg  <= tag_next;
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for time_ordered_message_queue: a queued driver, a stalling monitor and a
// sorted-queue predictor that checks every result. Depends on tomq_pkg and the queue RTL.
module tb_top;
    import tomq_pkg::*;

    localparam int DEPTH = DEFAULT_QUEUE_DEPTH;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_AT = 600;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [TIME_W-1:0]   msg_time;
        logic [TAG_W-1:0]    msg_tag;
        logic                safe_exit;
        bit                  drain_first;
    } queue_item_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [TIME_W-1:0]   out_time;
        logic [TAG_W-1:0]    out_tag;
        logic [OCC_W-1:0]    occupancy;
    } queue_result_t;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mode_t;
    typedef enum int {RX_FREE, RX_BUSY, RX_SLOW} rx_mode_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [ACTION_W-1:0] action = ACT_NOP;
    logic [TIME_W-1:0]   msg_time = '0;
    logic [TAG_W-1:0]    msg_tag = '0;
    logic                safe_exit = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   out_time;
    logic [TAG_W-1:0]    out_tag;
    logic [OCC_W-1:0]    occupancy;

    queue_item_t   pending_q[$];
    queue_result_t expected_q[$];

    logic [TIME_W-1:0] store_time [DEPTH];
    logic [TAG_W-1:0]  store_tag  [DEPTH];
    int                store_count = 0;
    bit                quit_seen = 1'b0;
    bit                quit_drains = 1'b0;

    int       total_items = 0;
    int       accepted_items = 0;
    int       received_results = 0;
    int       errors = 0;
    int       gap_left = 0;
    int       burst_left = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    int       rx_left = 0;
    rx_mode_t rx_mode = RX_FREE;
    int       idle_cycles = 0;

    time_ordered_message_queue #(.QUEUE_DEPTH(DEPTH)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .msg_time  (msg_time),
        .msg_tag   (msg_tag),
        .safe_exit (safe_exit),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .out_time  (out_time),
        .out_tag   (out_tag),
        .occupancy (occupancy)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic apply_queue_action(input queue_item_t it, output queue_result_t res);
        int pos;
        res.status = ST_OK;
        res.out_time = '0;
        res.out_tag = '0;
        case (it.action)
            ACT_ENQ:
            begin
                if (quit_seen)
                    res.status = ST_REJECT;
                else if (store_count >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < store_count && store_time[pos] <= it.msg_time)
                        pos++;
                    for (int i = store_count; i > pos; i--)
                    begin
                        store_time[i] = store_time[i-1];
                        store_tag[i] = store_tag[i-1];
                    end
                    store_time[pos] = it.msg_time;
                    store_tag[pos] = it.msg_tag;
                    store_count++;
                end
            end
            ACT_DEQ:
            begin
                if (quit_seen && !quit_drains)
                    res.status = ST_QUIT;
                else if (store_count == 0)
                    res.status = quit_seen ? ST_QUIT : ST_EMPTY;
                else
                begin
                    res.out_time = store_time[0];
                    res.out_tag = store_tag[0];
                    for (int i = 1; i < store_count; i++)
                    begin
                        store_time[i-1] = store_time[i];
                        store_tag[i-1] = store_tag[i];
                    end
                    store_count--;
                end
            end
            ACT_QUIT:
            begin
                quit_seen = 1'b1;
                quit_drains = it.safe_exit;
            end
            default:
            begin
            end
        endcase
        res.occupancy = OCC_W'(store_count);
    endtask

    task automatic add_item(input logic [ACTION_W-1:0] act, input logic [TIME_W-1:0] t,
                            input logic [TAG_W-1:0] tag, input logic safe, input bit drain);
        queue_item_t it;
        it.action = act;
        it.msg_time = t;
        it.msg_tag = tag;
        it.safe_exit = safe;
        it.drain_first = drain;
        pending_q.push_back(it);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        queue_item_t   head;
        queue_result_t res;
        bit            taken;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= ACT_NOP;
            msg_time <= '0;
            msg_tag <= '0;
            safe_exit <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
        end
        else
        begin
            taken = in_valid && in_ready;
            if (taken)
            begin
                head.action = action;
                head.msg_time = msg_time;
                head.msg_tag = msg_tag;
                head.safe_exit = safe_exit;
                head.drain_first = 1'b0;
                apply_queue_action(head, res);
                expected_q.push_back(res);
                accepted_items++;
            end
            if (in_valid && !taken)
            begin
            end
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_q.size() != 0 &&
                     !(pending_q[0].drain_first && expected_q.size() != 0))
            begin
                head = pending_q.pop_front();
                in_valid <= 1'b1;
                action <= head.action;
                msg_time <= head.msg_time;
                msg_tag <= head.msg_tag;
                safe_exit <= head.safe_exit;
                if (burst_left <= 1)
                begin
                    burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                               : $urandom_range(1, 12);
                    gap_left <= $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        queue_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            rx_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                received_results++;
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: status %0d time %h tag %h occupancy %0d",
                                 status, out_time, out_tag, occupancy);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (status !== want.status || out_time !== want.out_time ||
                        out_tag !== want.out_tag || occupancy !== want.occupancy)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("mismatch at result %0d:", received_results);
                            $display("  expected status %0d time %h tag %h occupancy %0d",
                                     want.status, want.out_time, want.out_tag,
                                     want.occupancy);
                            $display("  got      status %0d time %h tag %h occupancy %0d",
                                     status, out_time, out_tag, occupancy);
                        end
                    end
                end
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && received_results >= HOLD_AT)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode <= rx_mode_t'($urandom_range(0, 2));
                    rx_left <= $urandom_range(5, 50);
                end
                else
                    rx_left <= rx_left - 1;
                case (rx_mode)
                    RX_FREE: out_ready <= 1'b1;
                    RX_BUSY: out_ready <= ($urandom_range(0, 3) != 0);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int                  count;
        int                  mode_left;
        int                  pick;
        traffic_mode_t       mode;
        bit                  narrow;
        bit                  drain;
        logic [ACTION_W-1:0] act;
        logic [TIME_W-1:0]   t;

        add_item(ACT_DEQ, '1, '1, 1'b1, 1'b0);
        add_item(ACT_ENQ, '1, '1, 1'b1, 1'b0);
        add_item(ACT_ENQ, '0, '0, 1'b0, 1'b0);
        add_item(ACT_ENQ, 48'd100, 32'h11, 1'b0, 1'b0);
        add_item(ACT_ENQ, 48'd100, 32'h22, 1'b1, 1'b0);
        add_item(ACT_ENQ, 48'd100, 32'h33, 1'b0, 1'b0);
        add_item(ACT_ENQ, 48'h8000_0000_0000, 32'h8000_0000, 1'b0, 1'b0);
        add_item(ACT_NOP, '1, '1, 1'b1, 1'b0);
        repeat (7)
            add_item(ACT_DEQ, '0, '0, 1'b0, 1'b0);

        count = 0;
        mode_left = 0;
        mode = MIX_EVEN;
        narrow = 1'b0;
        drain = 1'b1;
        while (count < RANDOM_ITEMS)
        begin
            if (mode_left == 0)
            begin
                mode = traffic_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(10, 60);
                narrow = ($urandom_range(0, 1) == 0);
                if ($urandom_range(0, 7) == 0)
                    drain = 1'b1;
            end
            mode_left--;
            pick = $urandom_range(0, 99);
            case (mode)
                MIX_FILL:  act = (pick < 80) ? ACT_ENQ : ACT_DEQ;
                MIX_DRAIN: act = (pick < 80) ? ACT_DEQ : ACT_ENQ;
                default:   act = (pick < 50) ? ACT_ENQ : ACT_DEQ;
            endcase
            if (pick >= 98)
                act = ACT_NOP;
            t = narrow ? TIME_W'($urandom_range(0, 7)) : TIME_W'({$urandom(), $urandom()});
            add_item(act, t, $urandom(), 1'($urandom_range(0, 1)), drain);
            drain = 1'b0;
            if (act != ACT_NOP)
                count++;
        end

        add_item(ACT_ENQ, 48'd50, 32'hA, 1'b0, 1'b1);
        add_item(ACT_ENQ, 48'd20, 32'hB, 1'b1, 1'b0);
        add_item(ACT_ENQ, 48'd50, 32'hC, 1'b0, 1'b0);
        add_item(ACT_QUIT, '0, '0, 1'b1, 1'b0);
        add_item(ACT_DEQ, '0, '0, 1'b0, 1'b0);
        add_item(ACT_ENQ, 48'd5, 32'hD, 1'b0, 1'b0);
        add_item(ACT_QUIT, '1, '1, 1'b0, 1'b0);
        add_item(ACT_DEQ, '0, '0, 1'b1, 1'b0);
        add_item(ACT_ENQ, '1, '1, 1'b1, 1'b0);
        add_item(ACT_QUIT, '0, '0, 1'b1, 1'b0);
        repeat (DEPTH + 2)
            add_item(ACT_DEQ, '0, '0, 1'b0, 1'b0);
        add_item(ACT_ENQ, 48'd7, 32'hE, 1'b0, 1'b0);
        add_item(ACT_NOP, '0, '0, 1'b0, 1'b0);
        total_items = pending_q.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (accepted_items != total_items)
            @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

FILE: filelist.f
design/tomq_pkg.sv
design/tomq_cell.sv
design/time_ordered_message_queue.sv
sim/tb_top.sv
